// ===== rtl/osms_pkg.sv =====
// Package for the override and schedule mode selector.
// Holds payload structs, operation codes, constants and the front/back command struct.
`timescale 1ns / 1ps
`default_nettype none
package osms_pkg;

    localparam int INTERSECTIONS_DEF  = 6;
    localparam int SCHEDULE_DEPTH_DEF = 32;

    localparam logic [2:0]  TARGET_ALL  = 3'd7;
    localparam logic [10:0] DAY_MINUTES = 11'd1440;
    localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;

    typedef enum logic [2:0] {
        OP_CLEAR      = 3'd0,
        OP_ADD        = 3'd1,
        OP_PERSISTENT = 3'd2,
        OP_TEMPORARY  = 3'd3,
        OP_REVERT     = 3'd4,
        OP_RESUME     = 3'd5,
        OP_QUERY      = 3'd6,
        OP_UNUSED     = 3'd7
    } op_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  target;
        logic [1:0]  requested_mode;
        logic [10:0] day_minute;
        logic [15:0] dur_seconds;
        logic [63:0] now_ns;
    } in_item_t;

    typedef struct packed {
        logic ok;
        logic mode;
        logic priority_res;
        logic operator_active;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t         op;
        logic [2:0]  target;
        logic        mode;
        logic [10:0] minute;
        logic [63:0] now_ns;
        logic [15:0] dur_seconds;
        logic        valid_args;  // static checks passed
        logic        dur_zero;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_WALK,
        ST_RESULT
    } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/osms_front.sv =====
// Front end: accepts transactions, checks static fields and queues commands.
// Depends on osms_pkg. Two-entry queue to the back end.
`timescale 1ns / 1ps
`default_nettype none
module osms_front
    import osms_pkg::*;
#(
    parameter int INTERSECTIONS = INTERSECTIONS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  in_item_t      in_data,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd_data
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cls;
    logic       tgt_ok, push, pop;

    always_comb
    begin
        tgt_ok = (in_data.target < 3'(INTERSECTIONS)) || (in_data.target == TARGET_ALL);
        cls.op           = op_t'(in_data.operation);
        cls.target       = in_data.target;
        cls.mode         = in_data.requested_mode[0];
        cls.minute       = in_data.day_minute;
        cls.now_ns       = in_data.now_ns;
        cls.dur_seconds  = in_data.dur_seconds;
        cls.dur_zero     = (in_data.dur_seconds == 16'd0);
        unique case (op_t'(in_data.operation))
            OP_CLEAR:      cls.valid_args = 1'b1;
            OP_ADD:        cls.valid_args = tgt_ok && !in_data.requested_mode[1]
                                            && (in_data.day_minute < DAY_MINUTES);
            OP_PERSISTENT: cls.valid_args = tgt_ok && !in_data.requested_mode[1]
                                            && cls.dur_zero;
            OP_TEMPORARY:  cls.valid_args = tgt_ok && !in_data.requested_mode[1]
                                            && !cls.dur_zero;
            OP_REVERT:     cls.valid_args = tgt_ok && cls.dur_zero;
            OP_RESUME:     cls.valid_args = tgt_ok;
            OP_QUERY:      cls.valid_args = (in_data.target < 3'(INTERSECTIONS));
            default:       cls.valid_args = 1'b0;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_data  = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule
`default_nettype wire

// ===== rtl/osms_back.sv =====
// Back end: schedule table walk, override registers and result register.
// Depends on osms_pkg. Table is a memory read one entry per cycle.
`timescale 1ns / 1ps
`default_nettype none
module osms_back
    import osms_pkg::*;
#(
    parameter int INTERSECTIONS  = INTERSECTIONS_DEF,
    parameter int SCHEDULE_DEPTH = SCHEDULE_DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  cmd_t          cmd_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_item_t     out_data
);

    localparam int AW = (SCHEDULE_DEPTH > 1) ? $clog2(SCHEDULE_DEPTH) : 1;
    localparam int CW = $clog2(SCHEDULE_DEPTH + 1);
    localparam int IW = (INTERSECTIONS > 1) ? $clog2(INTERSECTIONS) : 1;

    logic [10:0] mem_minute [SCHEDULE_DEPTH];
    logic [2:0]  mem_target [SCHEDULE_DEPTH];
    logic        mem_mode   [SCHEDULE_DEPTH];
    logic [10:0] rd_minute;
    logic [2:0]  rd_target;
    logic        rd_mode;

    logic [INTERSECTIONS-1:0] p_on_reg, p_on_next;
    logic [INTERSECTIONS-1:0] p_val_reg, p_val_next;
    logic [INTERSECTIONS-1:0] t_val_reg, t_val_next;
    logic [63:0]              t_exp_reg [INTERSECTIONS];
    logic [63:0]              t_exp_next [INTERSECTIONS];

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rd_valid_reg, rd_valid_next;   // read data belongs to idx_reg-1
    logic [10:0]   best_reg, best_next;
    logic          sel_reg, sel_next;
    logic          hit_reg, hit_next;
    out_item_t     res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   prod_reg, prod_next;

    logic [IW-1:0] qt;
    logic          tmp_live, op_act;
    logic [11:0]   diff;
    logic [10:0]   el;
    logic [64:0]   sum;
    logic [45:0]   prod_full;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    assign qt        = cmd_reg.target[IW-1:0];
    assign tmp_live  = t_exp_reg[qt] > cmd_reg.now_ns;
    assign op_act    = p_on_reg[qt] || tmp_live;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;
    assign prod_full = cmd_reg.dur_seconds * NS_PER_SEC;
    assign sum       = {1'b0, cmd_reg.now_ns} + {1'b0, prod_reg};
    assign rd_addr   = idx_reg[AW-1:0];

    always_comb
    begin
        diff = {1'b0, cmd_reg.minute} - {1'b0, rd_minute};
        el   = diff[11] ? 11'(diff + {1'b0, DAY_MINUTES}) : diff[10:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rd_valid_next  = 1'b0;
        best_next      = best_reg;
        sel_next       = sel_reg;
        hit_next       = hit_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        prod_next      = prod_reg;
        p_on_next      = p_on_reg;
        p_val_next     = p_val_reg;
        t_val_next     = t_val_reg;
        t_exp_next     = t_exp_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next  = cmd_data;
                    idx_next  = '0;
                    best_next = DAY_MINUTES;
                    sel_next  = 1'b0;
                    hit_next  = 1'b0;
                    if (cmd_data.op == OP_TEMPORARY && cmd_data.valid_args)
                        state_next = ST_MULT;
                    else if ((cmd_data.op == OP_ADD || cmd_data.op == OP_QUERY)
                             && cmd_data.valid_args)
                        state_next = ST_WALK;
                    else
                        state_next = ST_RESULT;
                end
            end
            ST_MULT:
            begin
                prod_next  = 64'(prod_full);
                state_next = ST_RESULT;
            end
            ST_WALK:
            begin
                // evaluate entry read last cycle
                if (rd_valid_reg)
                begin
                    if (cmd_reg.op == OP_ADD)
                    begin
                        if (rd_minute == cmd_reg.minute &&
                            (rd_target == cmd_reg.target || rd_target == TARGET_ALL ||
                             cmd_reg.target == TARGET_ALL))
                            hit_next = 1'b1;
                    end
                    else if (rd_target == TARGET_ALL || rd_target == cmd_reg.target)
                    begin
                        if (el < best_reg)
                        begin
                            best_next = el;
                            sel_next  = rd_mode;
                        end
                    end
                end
                if (idx_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    unique case (cmd_reg.op)
                        OP_CLEAR:
                        begin
                            res_next.ok = 1'b1;
                            count_next  = '0;
                        end
                        OP_ADD:
                        begin
                            if (cmd_reg.valid_args && !hit_reg &&
                                count_reg != CW'(SCHEDULE_DEPTH))
                            begin
                                res_next.ok = 1'b1;
                                wr_en       = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        OP_PERSISTENT, OP_TEMPORARY, OP_REVERT, OP_RESUME:
                        begin
                            if (cmd_reg.valid_args &&
                                !(cmd_reg.op == OP_TEMPORARY && sum[64]))
                            begin
                                res_next.ok = 1'b1;
                                for (int i = 0; i < INTERSECTIONS; i++)
                                begin
                                    if (cmd_reg.target == TARGET_ALL ||
                                        cmd_reg.target == 3'(i))
                                    begin
                                        case (cmd_reg.op)
                                            OP_PERSISTENT:
                                            begin
                                                p_on_next[i]  = 1'b1;
                                                p_val_next[i] = cmd_reg.mode;
                                                t_exp_next[i] = '0;
                                            end
                                            OP_TEMPORARY:
                                            begin
                                                t_val_next[i] = cmd_reg.mode;
                                                t_exp_next[i] = sum[63:0];
                                            end
                                            OP_REVERT:
                                                t_exp_next[i] = '0;
                                            default:
                                            begin
                                                p_on_next[i]  = 1'b0;
                                                t_exp_next[i] = '0;
                                            end
                                        endcase
                                    end
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            if (cmd_reg.valid_args)
                            begin
                                res_next.operator_active = op_act;
                                if (cmd_reg.minute < DAY_MINUTES)
                                begin
                                    if (tmp_live)
                                    begin
                                        res_next.ok           = 1'b1;
                                        res_next.mode         = t_val_reg[qt];
                                        res_next.priority_res = 1'b1;
                                    end
                                    else if (p_on_reg[qt])
                                    begin
                                        res_next.ok           = 1'b1;
                                        res_next.mode         = p_val_reg[qt];
                                        res_next.priority_res = 1'b1;
                                    end
                                    else if (best_reg != DAY_MINUTES)
                                    begin
                                        res_next.ok   = 1'b1;
                                        res_next.mode = sel_reg;
                                    end
                                end
                            end
                        end
                        default:
                            res_next = '0;
                    endcase
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            p_on_reg      <= '0;
            p_val_reg     <= '0;
            t_val_reg     <= '0;
            for (int i = 0; i < INTERSECTIONS; i++)
                t_exp_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rd_valid_reg  <= rd_valid_next;
            p_on_reg      <= p_on_next;
            p_val_reg     <= p_val_next;
            t_val_reg     <= t_val_next;
            t_exp_reg     <= t_exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        best_reg <= best_next;
        sel_reg  <= sel_next;
        hit_reg  <= hit_next;
        res_reg  <= res_next;
        prod_reg <= prod_next;
    end

    // schedule table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_minute[count_reg[AW-1:0]] <= cmd_reg.minute;
            mem_target[count_reg[AW-1:0]] <= cmd_reg.target;
            mem_mode[count_reg[AW-1:0]]   <= cmd_reg.mode;
        end
        if (rd_en)
        begin
            rd_minute <= mem_minute[rd_addr];
            rd_target <= mem_target[rd_addr];
            rd_mode   <= mem_mode[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/override_and_schedule_mode_selector_core.sv =====
// Override and schedule mode selector: one result per transaction.
// Path from input accept to result valid: the front queue, then the back end states ST_IDLE,
// ST_MULT for a valid temporary or ST_WALK for a valid add/query, and ST_RESULT, which
// loads the result register. Throughput: the back end takes one transaction at a time
// (serial table walk, one entry per cycle) and a stalled result holds it.
// Reset: asynchronous active low; clears table count, overrides and queues.
`timescale 1ns / 1ps
`default_nettype none
module override_and_schedule_mode_selector_core
    import osms_pkg::*;
#(
    parameter int INTERSECTIONS  = INTERSECTIONS_DEF,
    parameter int SCHEDULE_DEPTH = SCHEDULE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_data
);

    logic cmd_valid, cmd_ready;
    cmd_t cmd_data;

    osms_front #(
        .INTERSECTIONS (INTERSECTIONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    osms_back #(
        .INTERSECTIONS  (INTERSECTIONS),
        .SCHEDULE_DEPTH (SCHEDULE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for override_and_schedule_mode_selector_core.
// Drives random and directed commands through valid/ready, predicts results with a
// behavioral model of schedule table and overrides; depends on rtl/osms_pkg.sv.
`timescale 1ns / 1ps
module tb_top;
    import osms_pkg::*;

    localparam int NI = 6;
    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;

    override_and_schedule_mode_selector_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [10:0] sched_minute [DEPTH];
    logic [2:0]  sched_target [DEPTH];
    logic        sched_mode [DEPTH];
    int          sched_count;
    logic        pers_on [NI];
    logic        pers_val [NI];
    logic        temp_val [NI];
    logic [63:0] temp_expiry [NI];

    out_item_t expected_q [$];
    int errors = 0;
    int cycles = 0;
    bit hold_off = 0;

    function automatic bit target_valid(logic [2:0] t);
        return (t < NI) || (t == TARGET_ALL);
    endfunction

    function automatic out_item_t predict_command(in_item_t it);
        out_item_t r;
        logic [63:0] d;
        logic [63:0] expires;
        int b;
        int e;
        int best;
        int el;
        bit hit;
        r = '0;
        expires = '0;
        case (op_t'(it.operation))
            OP_CLEAR:
            begin
                sched_count = 0;
                r.ok = 1'b1;
            end
            OP_ADD:
            begin
                if (it.day_minute < DAY_MINUTES && target_valid(it.target)
                    && it.requested_mode <= 1 && sched_count < DEPTH)
                begin
                    r.ok = 1'b1;
                    for (int i = 0; i < sched_count; i++)
                        if (sched_minute[i] == it.day_minute &&
                            (sched_target[i] == it.target || sched_target[i] == TARGET_ALL
                             || it.target == TARGET_ALL))
                            r.ok = 1'b0;
                    if (r.ok)
                    begin
                        sched_minute[sched_count] = it.day_minute;
                        sched_target[sched_count] = it.target;
                        sched_mode[sched_count] = it.requested_mode[0];
                        sched_count++;
                    end
                end
            end
            OP_PERSISTENT, OP_TEMPORARY, OP_REVERT, OP_RESUME:
            begin
                r.ok = target_valid(it.target);
                if (it.operation == OP_PERSISTENT || it.operation == OP_TEMPORARY)
                    if (it.requested_mode > 1)
                        r.ok = 1'b0;
                if ((it.operation == OP_PERSISTENT || it.operation == OP_REVERT)
                    && it.dur_seconds != 0)
                    r.ok = 1'b0;
                if (it.operation == OP_TEMPORARY)
                begin
                    d = 64'(it.dur_seconds) * 64'd1000000000;
                    if (it.dur_seconds == 0 || it.now_ns > ~64'd0 - d)
                        r.ok = 1'b0;
                    expires = it.now_ns + d;
                end
                if (r.ok)
                begin
                    b = (it.target == TARGET_ALL) ? 0 : it.target;
                    e = (it.target == TARGET_ALL) ? NI : it.target + 1;
                    for (int i = b; i < e; i++)
                        case (op_t'(it.operation))
                            OP_PERSISTENT:
                            begin
                                pers_on[i] = 1'b1;
                                pers_val[i] = it.requested_mode[0];
                                temp_expiry[i] = '0;
                            end
                            OP_TEMPORARY:
                            begin
                                temp_val[i] = it.requested_mode[0];
                                temp_expiry[i] = expires;
                            end
                            OP_REVERT: temp_expiry[i] = '0;
                            default:
                            begin
                                pers_on[i] = 1'b0;
                                temp_expiry[i] = '0;
                            end
                        endcase
                end
            end
            OP_QUERY:
            begin
                if (it.target < NI)
                begin
                    r.operator_active = pers_on[it.target] ||
                                        (temp_expiry[it.target] > it.now_ns);
                    if (it.day_minute < DAY_MINUTES)
                    begin
                        if (temp_expiry[it.target] > it.now_ns)
                        begin
                            r.ok = 1'b1;
                            r.mode = temp_val[it.target];
                            r.priority_res = 1'b1;
                        end
                        else if (pers_on[it.target])
                        begin
                            r.ok = 1'b1;
                            r.mode = pers_val[it.target];
                            r.priority_res = 1'b1;
                        end
                        else
                        begin
                            best = 1440;
                            hit = 0;
                            for (int i = 0; i < sched_count; i++)
                            begin
                                if (sched_target[i] != TARGET_ALL &&
                                    sched_target[i] != it.target)
                                    continue;
                                el = (int'(it.day_minute) + 1440 -
                                      int'(sched_minute[i])) % 1440;
                                if (el < best)
                                begin
                                    best = el;
                                    r.mode = sched_mode[i];
                                    hit = 1;
                                end
                            end
                            r.ok = hit;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // valid stays high between back-to-back transactions; dropped only for a gap
    task automatic send_command(in_item_t it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(predict_command(it));
    endtask

    function automatic in_item_t make_cmd(op_t op, logic [2:0] t, logic [1:0] m,
                                          logic [10:0] min, logic [15:0] dur,
                                          logic [63:0] now);
        in_item_t it;
        it.operation = op;
        it.target = t;
        it.requested_mode = m;
        it.day_minute = min;
        it.dur_seconds = dur;
        it.now_ns = now;
        return it;
    endfunction

    function automatic logic [63:0] rand_time();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return ~64'd0 - 64'($urandom_range(0, 3)) * 64'd1000000000;
            default: return 64'($urandom_range(0, 200)) * 64'd1000000000;
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_command(make_cmd(OP_QUERY, 3'd0, 2'd0, 11'd0, 16'd0, 64'd0));
        send_command(make_cmd(OP_ADD, 3'd0, 2'd1, 11'd0, 16'd0, 64'd0));
        send_command(make_cmd(OP_ADD, 3'd7, 2'd0, 11'd0, 16'd0, 64'd0));
        send_command(make_cmd(OP_ADD, 3'd7, 2'd0, 11'd1439, 16'd0, 64'd0));
        send_command(make_cmd(OP_ADD, 3'd1, 2'd0, 11'd1440, 16'd0, 64'd0));
        send_command(make_cmd(OP_ADD, 3'd6, 2'd0, 11'd5, 16'd0, 64'd0));
        send_command(make_cmd(OP_ADD, 3'd2, 2'd3, 11'd5, 16'd0, 64'd0));
        send_command(make_cmd(OP_QUERY, 3'd3, 2'd2, 11'd1438, 16'd0, 64'd0));
        send_command(make_cmd(OP_QUERY, 3'd0, 2'd0, 11'd2047, 16'd0, 64'd0));
        send_command(make_cmd(OP_QUERY, 3'd7, 2'd0, 11'd10, 16'd0, 64'd0));
        send_command(make_cmd(OP_PERSISTENT, 3'd2, 2'd1, 11'd0, 16'd0, 64'd0));
        send_command(make_cmd(OP_PERSISTENT, 3'd2, 2'd1, 11'd0, 16'd1, 64'd0));
        send_command(make_cmd(OP_TEMPORARY, 3'd7, 2'd0, 11'd0, 16'hffff, 64'd5));
        send_command(make_cmd(OP_TEMPORARY, 3'd1, 2'd0, 11'd0, 16'd1, ~64'd0));
        send_command(make_cmd(OP_TEMPORARY, 3'd1, 2'd2, 11'd0, 16'd0, 64'd0));
        send_command(make_cmd(OP_QUERY, 3'd2, 2'd0, 11'd3, 16'd0, 64'd6));
        send_command(make_cmd(OP_REVERT, 3'd7, 2'd0, 11'd0, 16'd0, 64'd0));
        send_command(make_cmd(OP_REVERT, 3'd2, 2'd0, 11'd0, 16'd5, 64'd0));
        send_command(make_cmd(OP_QUERY, 3'd2, 2'd0, 11'd3, 16'd0, ~64'd0));
        send_command(make_cmd(OP_RESUME, 3'd7, 2'd3, 11'd0, 16'd0, 64'd0));
        send_command(make_cmd(OP_RESUME, 3'd6, 2'd0, 11'd0, 16'd0, 64'd0));
        send_command(make_cmd(OP_QUERY, 3'd2, 2'd0, 11'd3, 16'd0, 64'd0));
        send_command(make_cmd(OP_UNUSED, 3'd0, 2'd0, 11'd0, 16'd0, 64'd0));
        send_command(make_cmd(OP_CLEAR, 3'd5, 2'd3, 11'd2047, 16'hffff, ~64'd0));
        wait_drained();
    endtask

    // send DEPTH + 2 adds at distinct minutes, aiming to fill the table and overflow it, then queries
    task automatic test_full_table();
        for (int i = 0; i < DEPTH + 2; i++)
            send_command(make_cmd(OP_ADD, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 1)),
                                  11'(i * 40 + $urandom_range(0, 39)), 16'd0, 64'd0));
        for (int i = 0; i < 10; i++)
            send_command(make_cmd(OP_QUERY, 3'($urandom_range(0, 5)), 2'd0,
                                  11'($urandom_range(0, 1439)), 16'd0, 64'd0));
    endtask

    task automatic test_random(int n);
        in_item_t it;
        for (int k = 0; k < n; k++)
        begin
            it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
            if ($urandom_range(0, 9) != 0)
            begin
                it.operation = 3'($urandom_range(0, 6));
                if (it.operation == OP_CLEAR && $urandom_range(0, 3) != 0)
                    it.operation = OP_QUERY;
                it.target = $urandom_range(0, 3) == 0 ? 3'($urandom) :
                            ($urandom_range(0, 4) == 0 ? TARGET_ALL : 3'($urandom_range(0, 5)));
                it.requested_mode = $urandom_range(0, 7) == 0 ? 2'($urandom) :
                                    2'($urandom_range(0, 1));
                it.day_minute = $urandom_range(0, 7) == 0 ? 11'($urandom) :
                                11'($urandom_range(0, 1439));
                if ($urandom_range(0, 2) == 0)
                    it.day_minute = 11'($urandom_range(0, 7) * 180);
                it.dur_seconds = $urandom_range(0, 1) ? 16'd0 :
                                 ($urandom_range(0, 5) == 0 ? 16'($urandom) :
                                  16'($urandom_range(1, 60)));
                if (it.operation == OP_TEMPORARY && it.dur_seconds == 0
                    && $urandom_range(0, 3) != 0)
                    it.dur_seconds = 16'($urandom_range(1, 60));
                it.now_ns = rand_time();
            end
            send_command(it);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        test_random(20);
        hold_off = 0;
        wait_drained();
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t exp_r;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none actual %b",
                         $time, out_data);
                errors <= errors + 1;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (exp_r !== out_data)
                begin
                    $display("%0t: result expected %b actual %b (ok mode prio act)",
                             $time, exp_r, out_data);
                    errors <= errors + 1;
                end
            end
        end
    end

    // receiver: random stall per transaction, long hold-off on request
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                @(posedge clk);
                while (!out_valid && !hold_off)
                    @(posedge clk);
            end
        end
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("override_and_schedule_mode_selector_core: mismatch");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        sched_count = 0;
        for (int i = 0; i < NI; i++)
        begin
            pers_on[i] = 0;
            pers_val[i] = 0;
            temp_val[i] = 0;
            temp_expiry[i] = '0;
        end
        @(posedge clk);
        test_directed();
        test_full_table();
        test_backpressure();
        test_random(850);
        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("override_and_schedule_mode_selector_core: match");
        else
            $display("override_and_schedule_mode_selector_core: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/osms_pkg.sv
rtl/osms_front.sv
rtl/osms_back.sv
rtl/override_and_schedule_mode_selector_core.sv
verif/tb_top.sv
